/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge
`define MST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed: property violated");

// condition must never be seen at a clock edge
`define MST_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("assertion failed: forbidden condition seen");

`endif

/* hdl/mst_pkg.sv */
// ----------------------------------------------------------------------------
// mst_pkg
// shared constants for the prim spanning tree core and its register block
// ----------------------------------------------------------------------------
`default_nettype none

package mst_pkg;

  // default sizing
  localparam int unsigned MST_MAX_VERTICES = 32;
  localparam int unsigned MST_WEIGHT_BITS  = 16;

  // fixed field widths
  localparam int unsigned VIDX_W   = 5;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned VCOUNT_W = 6;
  localparam int unsigned CLAMP_W  = 7;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RST = 6'd32;

  // apb register port
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 2;
  localparam logic [APB_ADDR_W-1:0] REG_VERTEX_COUNT_ADDR = 2'b00;

endpackage

`default_nettype wire

/* hdl/mst_cfg.sv */
// ----------------------------------------------------------------------------
// mst_cfg
// apb register block holding the vertex count, clamped to the usable range
// ----------------------------------------------------------------------------
`default_nettype none

module mst_cfg
  import mst_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MST_MAX_VERTICES,
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic      [CW-1:0]         count_o
);

  localparam logic [CLAMP_W-1:0] MaxV = CLAMP_W'(MAX_VERTICES);

  logic [VCOUNT_W-1:0] vcount_q, vcount_d;
  logic [CLAMP_W-1:0]  vc_ext;
  logic [CLAMP_W-1:0]  clamped;
  logic                wr_beat;

  assign pready  = 1'b1;
  assign wr_beat = psel && penable && pwrite;

  always_comb begin
    vcount_d = vcount_q;
    if (wr_beat) begin
      vcount_d = pwdata[VCOUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VCOUNT_RST;
    end else begin
      vcount_q <= vcount_d;
    end
  end

  assign prdata = (paddr == REG_VERTEX_COUNT_ADDR) ?
                  {{(APB_DATA_W-VCOUNT_W){1'b0}}, vcount_q} : '0;

  // zero acts as one, anything above the array size acts as the array size
  assign vc_ext = {1'b0, vcount_q};

  always_comb begin
    if (vc_ext == '0) begin
      clamped = CLAMP_W'(1);
    end else if (vc_ext > MaxV) begin
      clamped = MaxV;
    end else begin
      clamped = vc_ext;
    end
  end

  assign count_o = clamped[CW-1:0];

endmodule

`default_nettype wire

/* hdl/minimum_spanning_tree_prim_core.sv */
// sequence: matrix entries load while idle; after the last entry, n rounds of
//   a key scan and a relax pass, a final scan and an emit pass for n vertices
// throughput: one run at a time, busy high until the last edge is issued, paced
//   by one key read port and one comparator; n-1 beats, receiver cannot stall
// reset: control state, visited and parent flags clear; the vertex count is 32
// ----------------------------------------------------------------------------
// minimum_spanning_tree_prim_core
// prim spanning tree over a loaded adjacency matrix, iterative shared compare
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module minimum_spanning_tree_prim_core
  import mst_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MST_MAX_VERTICES,
  parameter int unsigned WEIGHT_BITS  = MST_WEIGHT_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // apb configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  // load command
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [VIDX_W-1:0]     row_vertex_i,
  input  wire logic [VIDX_W-1:0]     col_vertex_i,
  input  wire logic [WEIGHT_W-1:0]   edge_weight_i,
  input  wire logic                  load_last_i,
  // tree edges
  output logic                       strobe,
  output logic      [VIDX_W-1:0]     end_low_o,
  output logic      [VIDX_W-1:0]     end_high_o,
  output logic      [WEIGHT_W-1:0]   tree_weight_o,
  output logic                       reachable_o,
  output logic                       edge_last_o
);

  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned AW = $clog2(MAX_VERTICES * MAX_VERTICES);
  localparam int unsigned WB = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
  localparam int unsigned KW = WEIGHT_BITS + 1;
  localparam int unsigned KE = WB + VW;
  localparam logic [CLAMP_W-1:0] MaxV = CLAMP_W'(MAX_VERTICES);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_RELAX = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  function automatic logic [VIDX_W-1:0] to_vid(input logic [VW-1:0] v);
    logic [VW+VIDX_W-1:0] t;
    t = {{VIDX_W{1'b0}}, v};
    return t[VIDX_W-1:0];
  endfunction

  function automatic logic [WEIGHT_W-1:0] to_wt(input logic [WB-1:0] w);
    logic [WB+WEIGHT_W-1:0] t;
    t = {{WEIGHT_W{1'b0}}, w};
    return t[WEIGHT_W-1:0];
  endfunction

  function automatic logic [VW-1:0] from_vid(input logic [VIDX_W-1:0] v);
    logic [VW+VIDX_W-1:0] t;
    t = {{VW{1'b0}}, v};
    return t[VW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  logic [CW-1:0] count;

  mst_cfg #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .count_o (count)
  );

  // ---------------------------------------------------------------------------
  // control state
  // ---------------------------------------------------------------------------
  state_e                  state_q, state_d;
  logic [CW-1:0]           n_q, n_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic                    stg_vld_q, stg_vld_d;
  logic [VW-1:0]           stg_idx_q, stg_idx_d;
  logic [VW-1:0]           pick_q, pick_d;
  logic [KW-1:0]           best_q, best_d;
  logic                    found_q, found_d;
  logic [MAX_VERTICES-1:0] visited_q, visited_d;
  logic [MAX_VERTICES-1:0] has_q, has_d;

  logic                    strobe_q, strobe_d;
  logic [VIDX_W-1:0]       low_q, low_d;
  logic [VIDX_W-1:0]       high_q, high_d;
  logic [WEIGHT_W-1:0]     wt_q, wt_d;
  logic                    reach_q, reach_d;
  logic                    last_q, last_d;

  logic                    accept;
  logic                    phase_end;
  logic                    issue;
  logic [VW-1:0]           rd_idx;

  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign phase_end = (cnt_q == n_q);
  assign issue     = !phase_end && (state_q != ST_IDLE);
  assign rd_idx    = cnt_q[VW-1:0];

  // ---------------------------------------------------------------------------
  // adjacency memory, one write port for loading, one read port for relaxing
  // ---------------------------------------------------------------------------
  logic [WB-1:0] adj_mem [MAX_VERTICES*MAX_VERTICES];
  logic [WB-1:0] adj_rd_q;
  logic          adj_we;
  logic [AW-1:0] adj_wa;
  logic [AW-1:0] adj_ra;
  logic          row_ok, col_ok;

  assign row_ok = ({{(CLAMP_W-VIDX_W){1'b0}}, row_vertex_i} < MaxV);
  assign col_ok = ({{(CLAMP_W-VIDX_W){1'b0}}, col_vertex_i} < MaxV);
  assign adj_we = accept && row_ok && col_ok;
  assign adj_wa = AW'(from_vid(row_vertex_i)) * AW'(MAX_VERTICES)
                + AW'(from_vid(col_vertex_i));
  assign adj_ra = AW'(pick_q) * AW'(MAX_VERTICES) + AW'(rd_idx);

  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_mem[adj_wa] <= edge_weight_i[WB-1:0];
    end
    adj_rd_q <= adj_mem[adj_ra];
  end

  // ---------------------------------------------------------------------------
  // key memory: {key, parent}, only meaningful where the parent flag is set
  // ---------------------------------------------------------------------------
  logic [KE-1:0] key_mem [MAX_VERTICES];
  logic [KE-1:0] key_rd_q;
  logic          key_we;

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[stg_idx_q] <= {adj_rd_q, pick_q};
    end
    key_rd_q <= key_mem[rd_idx];
  end

  // ---------------------------------------------------------------------------
  // shared comparator and stage decode
  // ---------------------------------------------------------------------------
  logic [WB-1:0] mem_key;
  logic [VW-1:0] mem_par;
  logic          stg_has;
  logic          stg_vis;
  logic [KW-1:0] eff_key;
  logic [KW-1:0] cmp_a, cmp_b;
  logic          lt;
  logic          cand;
  logic [VW-1:0] pick_nx;

  assign mem_key = key_rd_q[KE-1:VW];
  assign mem_par = key_rd_q[VW-1:0];
  assign stg_has = has_q[stg_idx_q];
  assign stg_vis = visited_q[stg_idx_q];

  // no parent yet: vertex 0 starts at zero, the rest at the sentinel
  assign eff_key = stg_has ? KW'(mem_key) : ((stg_idx_q == '0) ? '0 : '1);

  always_comb begin
    unique case (state_q)
      ST_RELAX: begin
        cmp_a = KW'(adj_rd_q);
        cmp_b = eff_key;
      end
      default: begin
        cmp_a = eff_key;
        cmp_b = best_q;
      end
    endcase
  end

  assign lt = (cmp_a < cmp_b);

  assign cand    = stg_vld_q && (state_q == ST_SCAN) && !stg_vis && (!found_q || lt);
  assign key_we  = stg_vld_q && (state_q == ST_RELAX) && (adj_rd_q != '0) && !stg_vis && lt;
  assign pick_nx = cand ? stg_idx_q : pick_q;

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    cnt_d     = issue ? cnt_q + CW'(1) : cnt_q;
    stg_vld_d = issue;
    stg_idx_d = rd_idx;
    pick_d    = pick_nx;
    best_d    = cand ? eff_key : best_q;
    found_d   = found_q || cand;
    visited_d = visited_q;
    has_d     = has_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept && load_last_i) begin
          n_d       = count;
          cnt_d     = '0;
          visited_d = '0;
          has_d     = '0;
          found_d   = 1'b0;
          state_d   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (phase_end) begin
          if (found_q || cand) begin
            visited_d[pick_nx] = 1'b1;
            found_d            = 1'b0;
            cnt_d              = '0;
            state_d            = ST_RELAX;
          end else begin
            cnt_d   = CW'(1);
            state_d = ST_EMIT;
          end
        end
      end
      ST_RELAX: begin
        if (key_we) begin
          has_d[stg_idx_q] = 1'b1;
        end
        if (phase_end) begin
          cnt_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_EMIT: begin
        if (phase_end) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      n_q       <= '0;
      cnt_q     <= '0;
      stg_vld_q <= 1'b0;
      stg_idx_q <= '0;
      pick_q    <= '0;
      best_q    <= '0;
      found_q   <= 1'b0;
      visited_q <= '0;
      has_q     <= '0;
      strobe_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      cnt_q     <= cnt_d;
      stg_vld_q <= stg_vld_d;
      stg_idx_q <= stg_idx_d;
      pick_q    <= pick_d;
      best_q    <= best_d;
      found_q   <= found_d;
      visited_q <= visited_d;
      has_q     <= has_d;
      strobe_q  <= strobe_d;
    end
  end

  // ---------------------------------------------------------------------------
  // result beats
  // ---------------------------------------------------------------------------
  logic par_lt;

  assign par_lt = (mem_par < stg_idx_q);

  always_comb begin
    strobe_d = stg_vld_q && (state_q == ST_EMIT);
    low_d    = low_q;
    high_d   = high_q;
    wt_d     = wt_q;
    reach_d  = reach_q;
    last_d   = last_q;
    if (strobe_d) begin
      if (stg_has) begin
        low_d   = to_vid(par_lt ? mem_par : stg_idx_q);
        high_d  = to_vid(par_lt ? stg_idx_q : mem_par);
        wt_d    = to_wt(mem_key);
        reach_d = 1'b1;
      end else begin
        low_d   = '0;
        high_d  = to_vid(stg_idx_q);
        wt_d    = '0;
        reach_d = 1'b0;
      end
      last_d = ((CW'(stg_idx_q) + CW'(1)) == n_q);
    end
  end

  always_ff @(posedge clk_i) begin
    low_q   <= low_d;
    high_q  <= high_d;
    wt_q    <= wt_d;
    reach_q <= reach_d;
    last_q  <= last_d;
  end

  assign strobe        = strobe_q;
  assign end_low_o     = low_q;
  assign end_high_o    = high_q;
  assign tree_weight_o = wt_q;
  assign reachable_o   = reach_q;
  assign edge_last_o   = last_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `MST_ASSERT(a_strobe_after_emit, strobe_q |-> $past(state_q == ST_EMIT))
  `MST_ASSERT(a_last_load_goes_busy, (start && !busy && load_last_i) |=> busy)
  `MST_ASSERT_NEVER(a_key_write_outside_relax, key_we && (state_q != ST_RELAX))
  `MST_ASSERT(a_pick_marked_visited,
              (state_q == ST_SCAN && phase_end && (found_q || cand)) |=> visited_q[pick_q])

endmodule

`default_nettype wire
